[rtl/core/pfm_pkg.sv]
// ----------------------------------------------------------------------------
// pfm_pkg: shared constants, types and functions for pose_from_three_markers
// Widths of the coordinate path, CORDIC arctangent table, the divide-by-three
// reciprocal, and the words passed between pipeline modules.
// ----------------------------------------------------------------------------
package pfm_pkg;

  // Coordinate width (signed Q12.12 at 24 bits) and CORDIC length
  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int TAB_LEN      = 24;
  localparam int NUM_STEPS    = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

  // Heading output, Q3.13 radians
  localparam int HEAD_W = 16;

  // Register indexes of the configuration port
  localparam logic REG_OFFSET_X = 1'b0;
  localparam logic REG_OFFSET_Y = 1'b1;

  // Sum of three coordinates, and magnitude plus one for the rounded divide
  localparam int SUM_W  = COORD_WIDTH + 2;
  localparam int A_W    = COORD_WIDTH + 1;
  localparam int DIV_K  = A_W + 1;
  localparam int PROD_W = 2 * A_W;
  localparam longint DIV_M_L = ((64'sd1 <<< DIV_K) + 64'sd2) / 3;
  localparam logic [A_W-1:0] DIV_M = A_W'(DIV_M_L);

  // CORDIC datapath: x/y with headroom for gain, angle in Q2.30
  localparam int CW  = COORD_WIDTH + 4;
  localparam int Z_W = 35;
  localparam longint ANG_PI_L   = 64'sd3373259426;
  localparam longint HEAD_MAX_L = 64'sd25736;
  localparam logic signed [Z_W-1:0] ANG_PI   = Z_W'(ANG_PI_L);
  localparam logic signed [Z_W-1:0] HEAD_MAX = Z_W'(HEAD_MAX_L);
  localparam logic signed [Z_W-1:0] Z_HALF   = Z_W'(64'sd65536);

  // Centroid stage output word
  typedef struct packed {
    logic                          valid;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] tx;
    logic signed [COORD_WIDTH-1:0] ty;
  } cent_t;

  // Word handed from one CORDIC cell to the next
  typedef struct packed {
    logic                          valid;
    logic                          zero;
    logic signed [CW-1:0]          x;
    logic signed [CW-1:0]          y;
    logic signed [Z_W-1:0]         z;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
  } cordic_t;

  // atan(2^-i) in Q2.30, truncated
  function automatic logic signed [Z_W-1:0] atan_of(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0:    r = Z_W'(64'sd843314856);
      5'd1:    r = Z_W'(64'sd497837829);
      5'd2:    r = Z_W'(64'sd263043836);
      5'd3:    r = Z_W'(64'sd133525158);
      5'd4:    r = Z_W'(64'sd67021686);
      5'd5:    r = Z_W'(64'sd33543515);
      5'd6:    r = Z_W'(64'sd16775850);
      5'd7:    r = Z_W'(64'sd8388437);
      5'd8:    r = Z_W'(64'sd4194282);
      5'd9:    r = Z_W'(64'sd2097149);
      5'd10:   r = Z_W'(64'sd1048575);
      5'd11:   r = Z_W'(64'sd524287);
      5'd12:   r = Z_W'(64'sd262143);
      5'd13:   r = Z_W'(64'sd131071);
      5'd14:   r = Z_W'(64'sd65535);
      5'd15:   r = Z_W'(64'sd32767);
      5'd16:   r = Z_W'(64'sd16383);
      5'd17:   r = Z_W'(64'sd8191);
      5'd18:   r = Z_W'(64'sd4095);
      5'd19:   r = Z_W'(64'sd2047);
      5'd20:   r = Z_W'(64'sd1023);
      5'd21:   r = Z_W'(64'sd511);
      5'd22:   r = Z_W'(64'sd255);
      5'd23:   r = Z_W'(64'sd127);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a two-bit-wider signed value to the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [COORD_WIDTH+1:0] v
  );
    logic signed [COORD_WIDTH+1:0] hi;
    logic signed [COORD_WIDTH+1:0] lo;
    logic signed [COORD_WIDTH-1:0] r;
    hi = (COORD_WIDTH+2)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - (COORD_WIDTH+2)'(1);
    if (v > hi) begin
      r = hi[COORD_WIDTH-1:0];
    end else if (v < lo) begin
      r = lo[COORD_WIDTH-1:0];
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/pfm_centroid.sv]
// ----------------------------------------------------------------------------
// pfm_centroid: four-stage centroid of three marker points
// Sums the coordinates, then divides by three rounded to nearest through a
// reciprocal multiply on the magnitude plus one. Top marker rides along.
// ----------------------------------------------------------------------------
module pfm_centroid (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] left_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] left_y_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] right_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] right_y_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] top_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] top_y_i,
  output pfm_pkg::cent_t                         cent_o
);

  localparam int W = pfm_pkg::COORD_WIDTH;
  localparam int SW = pfm_pkg::SUM_W;
  localparam int AW = pfm_pkg::A_W;
  localparam int PW = pfm_pkg::PROD_W;
  localparam int K = pfm_pkg::DIV_K;

  logic [3:0] valid_q;
  logic signed [W-1:0] tx_q [4];
  logic signed [W-1:0] ty_q [4];

  logic signed [SW-1:0] sx_q, sy_q;
  logic negx2_q, negy2_q, negx3_q, negy3_q;
  logic [AW-1:0] ax_q, ay_q;
  logic [PW-1:0] px_q, py_q;
  logic signed [W-1:0] cx_q, cy_q;

  logic signed [SW-1:0] absx_d, absy_d;
  logic [W-1:0] qx_d, qy_d;

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  // top marker delay line
  always_ff @(posedge clk_i) begin
    tx_q[0] <= top_x_i;
    ty_q[0] <= top_y_i;
    for (int i = 1; i < 4; i++) begin
      tx_q[i] <= tx_q[i-1];
      ty_q[i] <= ty_q[i-1];
    end
  end

  // stage 1: sums of three coordinates
  always_ff @(posedge clk_i) begin
    sx_q <= SW'(left_x_i) + SW'(right_x_i) + SW'(top_x_i);
    sy_q <= SW'(left_y_i) + SW'(right_y_i) + SW'(top_y_i);
  end

  // stage 2: magnitude plus one, keep sign
  assign absx_d = sx_q[SW-1] ? -sx_q : sx_q;
  assign absy_d = sy_q[SW-1] ? -sy_q : sy_q;

  always_ff @(posedge clk_i) begin
    negx2_q <= sx_q[SW-1];
    negy2_q <= sy_q[SW-1];
    ax_q    <= AW'(absx_d) + AW'(1);
    ay_q    <= AW'(absy_d) + AW'(1);
  end

  // stage 3: multiply by the reciprocal of three
  always_ff @(posedge clk_i) begin
    negx3_q <= negx2_q;
    negy3_q <= negy2_q;
    px_q    <= PW'(ax_q) * PW'(pfm_pkg::DIV_M);
    py_q    <= PW'(ay_q) * PW'(pfm_pkg::DIV_M);
  end

  // stage 4: take the quotient and restore the sign
  assign qx_d = px_q[PW-1:K];
  assign qy_d = py_q[PW-1:K];

  always_ff @(posedge clk_i) begin
    cx_q <= negx3_q ? -$signed(qx_d) : $signed(qx_d);
    cy_q <= negy3_q ? -$signed(qy_d) : $signed(qy_d);
  end

  assign cent_o.valid = valid_q[3];
  assign cent_o.cx    = cx_q;
  assign cent_o.cy    = cy_q;
  assign cent_o.tx    = tx_q[3];
  assign cent_o.ty    = ty_q[3];

endmodule

[rtl/core/pfm_cordic_cell.sv]
// ----------------------------------------------------------------------------
// pfm_cordic_cell: one vectoring CORDIC micro-rotation
// Turns the vector toward the x axis by atan(2^-step) and accumulates the
// angle, then registers the word for the next cell.
// ----------------------------------------------------------------------------
module pfm_cordic_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [4:0]        step_i,
  input  pfm_pkg::cordic_t  word_i,
  output pfm_pkg::cordic_t  word_o
);

  logic signed [pfm_pkg::CW-1:0]  xs_d, ys_d;
  logic signed [pfm_pkg::Z_W-1:0] atan_d;
  logic                           up_d;
  logic                           valid_q;
  pfm_pkg::cordic_t               word_q;

  // shifted terms, floor rounding via arithmetic shift
  assign xs_d   = word_i.x >>> step_i;
  assign ys_d   = word_i.y >>> step_i;
  assign atan_d = pfm_pkg::atan_of(step_i);
  assign up_d   = !word_i.y[pfm_pkg::CW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= word_i.valid;
    end
  end

  // rotation step
  always_ff @(posedge clk_i) begin
    word_q.valid <= word_i.valid;
    word_q.zero  <= word_i.zero;
    word_q.pos_x <= word_i.pos_x;
    word_q.pos_y <= word_i.pos_y;
    if (up_d) begin
      word_q.x <= word_i.x + ys_d;
      word_q.y <= word_i.y - xs_d;
      word_q.z <= word_i.z + atan_d;
    end else begin
      word_q.x <= word_i.x - ys_d;
      word_q.y <= word_i.y + xs_d;
      word_q.z <= word_i.z - atan_d;
    end
  end

  always_comb begin
    word_o       = word_q;
    word_o.valid = valid_q;
  end

endmodule

[rtl/core/pose_from_three_markers.sv]
// ----------------------------------------------------------------------------
// pose_from_three_markers: robot pose from left, right and top markers
// Centroid, offset position and CORDIC heading in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// A marker triple is taken on any cycle with start_i high; busy_o stays low,
// so one word can enter every clock. Its pose appears with done_o after the
// centroid stages (sum, magnitude, reciprocal multiply, sign), a stage for
// position and heading vector, one for the half-plane pre-rotation, one per
// CORDIC cell and one for heading rounding. done_o is a single-cycle strobe
// and the receiver must take the word then. Offsets are written via cfg_we_i
// with cfg_idx_i selecting offset_x (0) or offset_y (1); the user must write
// them only while no item is in flight, as the block does not enforce this.
// ----------------------------------------------------------------------------
module pose_from_three_markers (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] left_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] left_y_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] right_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] right_y_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] top_x_i,
  input  logic signed [pfm_pkg::COORD_WIDTH-1:0] top_y_i,
  input  logic                                   cfg_we_i,
  input  logic                                   cfg_idx_i,
  input  logic [pfm_pkg::COORD_WIDTH-1:0]        cfg_wdata_i,
  output logic                                   done_o,
  output logic signed [pfm_pkg::COORD_WIDTH-1:0] pos_x_o,
  output logic signed [pfm_pkg::COORD_WIDTH-1:0] pos_y_o,
  output logic signed [pfm_pkg::HEAD_W-1:0]      heading_o
);

  localparam int W  = pfm_pkg::COORD_WIDTH;
  localparam int CW = pfm_pkg::CW;
  localparam int ZW = pfm_pkg::Z_W;
  localparam int N  = pfm_pkg::NUM_STEPS;

  logic signed [W-1:0] off_x_q, off_y_q;
  pfm_pkg::cent_t      cent;

  logic                signed [W+1:0] sum_x_d, sum_y_d;
  logic                v5_q;
  logic signed [W-1:0] px5_q, py5_q;
  logic signed [W:0]   dx5_q, dy5_q;

  pfm_pkg::cordic_t    chain [N+1];
  logic                v6_q;

  logic signed [ZW-1:0] zr_d;
  logic                 done_q;
  logic signed [W-1:0]  pos_x_q, pos_y_q;
  logic signed [pfm_pkg::HEAD_W-1:0] head_q;

  assign busy_o = 1'b0;

  // offset registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q <= '0;
      off_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pfm_pkg::REG_OFFSET_X: off_x_q <= $signed(cfg_wdata_i);
        pfm_pkg::REG_OFFSET_Y: off_y_q <= $signed(cfg_wdata_i);
        default:               off_x_q <= off_x_q;
      endcase
    end
  end

  // centroid pipeline
  pfm_centroid u_centroid (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i),
    .left_x_i  (left_x_i),
    .left_y_i  (left_y_i),
    .right_x_i (right_x_i),
    .right_y_i (right_y_i),
    .top_x_i   (top_x_i),
    .top_y_i   (top_y_i),
    .cent_o    (cent)
  );

  // stage 5: saturated position and heading vector
  assign sum_x_d = (W+2)'(cent.cx) + (W+2)'(off_x_q);
  assign sum_y_d = -((W+2)'(cent.cy) + (W+2)'(off_y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= cent.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    px5_q <= pfm_pkg::sat_coord(sum_x_d);
    py5_q <= pfm_pkg::sat_coord(sum_y_d);
    dx5_q <= (W+1)'(cent.tx) - (W+1)'(cent.cx);
    dy5_q <= (W+1)'(cent.ty) - (W+1)'(cent.cy);
  end

  // stage 6: fold the left half plane by pi
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    chain[0].valid <= v5_q;
    chain[0].zero  <= (dx5_q == '0) && (dy5_q == '0);
    chain[0].pos_x <= px5_q;
    chain[0].pos_y <= py5_q;
    if (dx5_q[W]) begin
      chain[0].x <= -CW'(dx5_q);
      chain[0].y <= -CW'(dy5_q);
      chain[0].z <= dy5_q[W] ? -pfm_pkg::ANG_PI : pfm_pkg::ANG_PI;
    end else begin
      chain[0].x <= CW'(dx5_q);
      chain[0].y <= CW'(dy5_q);
      chain[0].z <= '0;
    end
  end

  // row of CORDIC cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    pfm_pkg::cordic_t cell_in;

    always_comb begin
      cell_in = chain[g];
      if (g == 0) begin
        cell_in.valid = v6_q;
      end
    end

    pfm_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (5'(g)),
      .word_i (cell_in),
      .word_o (chain[g+1])
    );
  end

  // final stage: round angle to Q3.13 and clamp
  assign zr_d = (chain[N].z + pfm_pkg::Z_HALF) >>> 17;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_x_q <= chain[N].pos_x;
    pos_y_q <= chain[N].pos_y;
    if (chain[N].zero) begin
      head_q <= '0;
    end else if (zr_d > pfm_pkg::HEAD_MAX) begin
      head_q <= pfm_pkg::HEAD_W'(pfm_pkg::HEAD_MAX);
    end else if (zr_d < -pfm_pkg::HEAD_MAX) begin
      head_q <= pfm_pkg::HEAD_W'(-pfm_pkg::HEAD_MAX);
    end else begin
      head_q <= zr_d[pfm_pkg::HEAD_W-1:0];
    end
  end

  assign done_o    = done_q;
  assign pos_x_o   = pos_x_q;
  assign pos_y_o   = pos_y_q;
  assign heading_o = head_q;

endmodule
